// ===== src/gregorian_date_add_days_assert.svh =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days assertion macros
// concurrent checks that vanish when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

`ifndef ASSERT_OFF
`define GDAD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gdad assertion failed");
`define GDAD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("gdad forbidden condition seen");
`else
`define GDAD_ASSERT(label, clk, rst, prop)
`define GDAD_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== src/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// shared types, constants and calendar tables for the date add block
// ----------------------------------------------------------------------------
package gdad_pkg;

   localparam int AddBits  = 16;
   // running day count must hold any stored day plus the full count
   localparam int AccWidth = ((AddBits > 5) ? AddBits : 5) + 1;

   localparam logic [4:0]  ResetDay      = 5'd1;
   localparam logic [3:0]  ResetMonth    = 4'd1;
   localparam logic [15:0] ResetYear     = 16'd2000;
   localparam logic        ResetLeap     = 1'b1;
   localparam logic [3:0]  LastMonth     = 4'd12;
   localparam logic [3:0]  FirstMonth    = 4'd1;

   // odd divisor test: y divisible by 25 iff y * inv(25) mod 2^16 <= 65535 / 25
   localparam logic [15:0] Div25Inverse  = 16'd23593;
   localparam logic [15:0] Div25Limit    = 16'd2621;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_ADVANCE = 2'd1,
      ACT_COMPARE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEAP,
      ST_WALK,
      ST_DONE
   } state_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // days in the months before this one, out-of-range months count 31 days
   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      begin
         case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            4'd13:   base = 9'd365;
            4'd14:   base = 9'd396;
            default: base = 9'd427;
         endcase
         return base + 9'((leap && month > 4'd2) ? 1 : 0);
      end
   endfunction

endpackage

// ===== src/gregorian_date_add_days.sv =====
// load goes through the leap state to done, compare and the unused action go straight to done
// advance walks the months, with a leap refresh at each year boundary crossed, then goes to done
// the month walk through one shared subtract and compare sets the advance time
// one item at a time; done holds while an older result is untaken, the next item is taken while a result waits
// synchronous reset sets the date to 1 january 2000, no result pending
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// stored gregorian date with load, advance by days and compare actions
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_given_day,
   input  logic [3:0]  req_given_month,
   input  logic [15:0] req_given_year,
   input  logic [15:0] req_days_to_add,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_out_day,
   output logic [3:0]  rsp_out_month,
   output logic [15:0] rsp_out_year,
   output logic [8:0]  rsp_day_of_year,
   output logic        rsp_is_before,
   output logic        rsp_is_same
);

   localparam int AccWidth = gdad_pkg::AccWidth;

   gdad_pkg::state_type  state_ff, state_in;
   gdad_pkg::action_type op_ff, op_in;
   gdad_pkg::action_type action;

   logic [4:0]          day_ff, day_in;
   logic [3:0]          month_ff, month_in;
   logic [15:0]         year_ff, year_in;
   logic [AccWidth-1:0] acc_ff, acc_in;
   logic                before_ff, before_in;
   logic                same_ff, same_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [4:0]          rsp_day_ff, rsp_day_in;
   logic [3:0]          rsp_month_ff, rsp_month_in;
   logic [15:0]         rsp_year_ff, rsp_year_in;
   logic [8:0]          rsp_doy_ff, rsp_doy_in;
   logic                rsp_is_before_ff, rsp_is_before_in;
   logic                rsp_is_same_ff, rsp_is_same_in;

   logic                leap;
   logic                leap_update;
   logic [4:0]          cur_len;
   logic [gdad_pkg::AddBits-1:0] count;

   assign action = gdad_pkg::action_type'(req_action);
   assign count  = gdad_pkg::AddBits'(req_days_to_add);
   assign cur_len = gdad_pkg::month_len(month_ff, leap);

   gdad_leap_unit u_leap (
      .clock  (clock),
      .reset  (reset),
      .update (leap_update),
      .year   (year_ff),
      .leap   (leap)
   );

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      day_in           = day_ff;
      month_in         = month_ff;
      year_in          = year_ff;
      acc_in           = acc_ff;
      before_in        = before_ff;
      same_in          = same_ff;
      leap_update      = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_day_in       = rsp_day_ff;
      rsp_month_in     = rsp_month_ff;
      rsp_year_in      = rsp_year_ff;
      rsp_doy_in       = rsp_doy_ff;
      rsp_is_before_in = rsp_is_before_ff;
      rsp_is_same_in   = rsp_is_same_ff;
      req_ready        = (state_ff == gdad_pkg::ST_IDLE);

      case (state_ff)
         gdad_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in     = action;
               before_in = 1'b0;
               same_in   = 1'b0;
               case (action)
                  gdad_pkg::ACT_LOAD: begin
                     day_in   = req_given_day;
                     month_in = req_given_month;
                     year_in  = req_given_year;
                     state_in = gdad_pkg::ST_LEAP;
                  end
                  gdad_pkg::ACT_ADVANCE: begin
                     acc_in   = AccWidth'(day_ff) + AccWidth'(count);
                     state_in = gdad_pkg::ST_WALK;
                  end
                  gdad_pkg::ACT_COMPARE: begin
                     before_in = {year_ff, month_ff, day_ff} <
                                 {req_given_year, req_given_month, req_given_day};
                     same_in   = {year_ff, month_ff, day_ff} ==
                                 {req_given_year, req_given_month, req_given_day};
                     state_in  = gdad_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = gdad_pkg::ST_DONE;
                  end
               endcase
            end
         end
         gdad_pkg::ST_LEAP: begin
            leap_update = 1'b1;
            state_in    = (op_ff == gdad_pkg::ACT_ADVANCE) ? gdad_pkg::ST_WALK
                                                           : gdad_pkg::ST_DONE;
         end
         gdad_pkg::ST_WALK: begin
            if (acc_ff > AccWidth'(cur_len)) begin
               acc_in = acc_ff - AccWidth'(cur_len);
               if (month_ff >= gdad_pkg::LastMonth) begin
                  // year rolls over, leap flag must follow before the next month
                  month_in = gdad_pkg::FirstMonth;
                  year_in  = year_ff + 16'd1;
                  state_in = gdad_pkg::ST_LEAP;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in   = acc_ff[4:0];
               state_in = gdad_pkg::ST_DONE;
            end
         end
         gdad_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_day_in       = day_ff;
               rsp_month_in     = month_ff;
               rsp_year_in      = year_ff;
               rsp_doy_in       = 9'(day_ff) + gdad_pkg::days_before(month_ff, leap);
               rsp_is_before_in = before_ff;
               rsp_is_same_in   = same_ff;
               state_in         = gdad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdad_pkg::ST_IDLE;
         day_ff       <= gdad_pkg::ResetDay;
         month_ff     <= gdad_pkg::ResetMonth;
         year_ff      <= gdad_pkg::ResetYear;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      acc_ff           <= acc_in;
      before_ff        <= before_in;
      same_ff          <= same_in;
      rsp_day_ff       <= rsp_day_in;
      rsp_month_ff     <= rsp_month_in;
      rsp_year_ff      <= rsp_year_in;
      rsp_doy_ff       <= rsp_doy_in;
      rsp_is_before_ff <= rsp_is_before_in;
      rsp_is_same_ff   <= rsp_is_same_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_day     = rsp_day_ff;
   assign rsp_out_month   = rsp_month_ff;
   assign rsp_out_year    = rsp_year_ff;
   assign rsp_day_of_year = rsp_doy_ff;
   assign rsp_is_before   = rsp_is_before_ff;
   assign rsp_is_same     = rsp_is_same_ff;

   // day count only shrinks while months are walked
   `GDAD_ASSERT(a_walk_shrinks, clock, reset, (state_ff == gdad_pkg::ST_WALK) |=> (acc_ff <= $past(acc_ff)))
   // leap flag at rest never set for a year not divisible by four
   `GDAD_ASSERT(a_leap_needs_four, clock, reset, (state_ff == gdad_pkg::ST_IDLE && year_ff[1:0] != 2'd0) |-> !leap)
   // a result only appears after the sequencer has finished an item
   `GDAD_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == gdad_pkg::ST_DONE))
   `GDAD_NEVER(a_flags_exclusive, clock, reset, rsp_valid_ff && rsp_is_before_ff && rsp_is_same_ff)

endmodule

// ===== src/gdad_leap_unit.sv =====
// ----------------------------------------------------------------------------
// gdad_leap_unit
// registered gregorian leap flag for the stored year, refreshed on request
// ----------------------------------------------------------------------------
module gdad_leap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        update,
   input  logic [15:0] year,
   output logic        leap
);

   logic [15:0] scaled;
   logic        div25;
   logic        leap_ff;
   logic        leap_in;

   assign scaled = 16'(year * gdad_pkg::Div25Inverse);
   assign div25  = (scaled <= gdad_pkg::Div25Limit);

   // by 100 means by 4 and 25, by 400 means by 16 and 25
   always_comb begin
      leap_in = leap_ff;
      if (update) begin
         leap_in = ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_ff <= gdad_pkg::ResetLeap;
      end else begin
         leap_ff <= leap_in;
      end
   end

   assign leap = leap_ff;

endmodule
